// ===== sv/min_stk_pkg.sv =====
package min_stk_pkg;

  // Number of entries in each of the two stacks.
  localparam int unsigned STACK_DEPTH = 256;
  // Fill count must hold STACK_DEPTH itself.
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned DEPTH_W = 9;
  localparam int unsigned STAT_W  = 2;

  // Command codes.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

  // Shift control shared by every cell of one chain.
  typedef struct packed {
    logic push;  // take the neighbor nearer the top
    logic pop;   // take the neighbor farther from the top
  } shift_ctrl_t;

endpackage

// ===== sv/min_stk_cell.sv =====
module min_stk_cell (
  input  logic                                   clk_i,
  input  min_stk_pkg::shift_ctrl_t               ctrl_i,
  input  logic signed [min_stk_pkg::DATA_W-1:0]  above_i,
  input  logic signed [min_stk_pkg::DATA_W-1:0]  below_i,
  output logic signed [min_stk_pkg::DATA_W-1:0]  value_o
);

  logic signed [min_stk_pkg::DATA_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.push) begin
      data_d = above_i;
    end else if (ctrl_i.pop) begin
      data_d = below_i;
    end
  end

  // Payload only; valid entries are tracked by the fill count.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign value_o = data_q;

endmodule

// ===== sv/min_tracking_stack.sv =====
// min_tracking_stack: LIFO stack of signed 32-bit values that also reports
// the smallest value currently held.
//
// Input channel (in_valid_i/in_ready_o): cmd_i selects push of push_value_i
// or pop of the top. Output channel (out_valid_o/out_ready_i): exactly one
// item per input item with top, minimum, empty flag, status and depth.
// Top and minimum read zero when the stack is empty.
//
// Storage is two chains of shift cells, one for values and one for running
// minima; the top of each stack always sits in cell 0, so a push or pop is a
// one-step shift of the whole chain and the entry below the top is always in
// cell 1. The result is registered: out_valid_o rises in the cycle after accept,
// and an item can be accepted every cycle while the output register is
// empty or being drained (one item per cycle sustained).
// If the receiver stalls, the result holds and in_ready_o drops until it is
// taken. A push onto a full stack is dropped (overflow status); a pop from an
// empty stack is ignored (underflow status).
// Reset clears both fill counts and the output valid; cell contents are not
// reset and are never read before being written.
module min_tracking_stack (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   cmd_i,
  input  logic signed [min_stk_pkg::DATA_W-1:0]  push_value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [min_stk_pkg::DATA_W-1:0]  top_value_o,
  output logic signed [min_stk_pkg::DATA_W-1:0]  min_value_o,
  output logic                                   is_empty_o,
  output logic [min_stk_pkg::STAT_W-1:0]         status_o,
  output logic [min_stk_pkg::DEPTH_W-1:0]        depth_used_o
);

  localparam int unsigned Depth = min_stk_pkg::STACK_DEPTH;
  localparam int unsigned CntW  = min_stk_pkg::CNT_W;
  localparam int unsigned DataW = min_stk_pkg::DATA_W;

  // Cell contents, index 0 is the top.
  logic signed [DataW-1:0] val_cell [Depth];
  logic signed [DataW-1:0] min_cell [Depth];

  logic [CntW-1:0] val_cnt_q, val_cnt_d;
  logic [CntW-1:0] min_cnt_q, min_cnt_d;

  min_stk_pkg::shift_ctrl_t val_ctrl, min_ctrl;

  logic                               fire;
  logic                               do_push, do_pop;
  logic [min_stk_pkg::STAT_W-1:0]     status_d;
  logic signed [DataW-1:0]            top_d, min_d;

  // Output register.
  logic                               out_valid_q;
  logic signed [DataW-1:0]            top_q, min_q;
  logic                               empty_q;
  logic [min_stk_pkg::STAT_W-1:0]     status_q;
  logic [min_stk_pkg::DEPTH_W-1:0]    depth_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    do_push  = 1'b0;
    do_pop   = 1'b0;
    status_d = min_stk_pkg::ST_OK;
    val_ctrl = '0;
    min_ctrl = '0;

    if (cmd_i == min_stk_pkg::CMD_PUSH) begin
      if (val_cnt_q == min_stk_pkg::CNT_FULL) begin
        status_d = min_stk_pkg::ST_OVERFLOW;
      end else begin
        do_push = 1'b1;
      end
    end else begin
      if (val_cnt_q == '0) begin
        status_d = min_stk_pkg::ST_UNDERFLOW;
      end else begin
        do_pop = 1'b1;
      end
    end

    val_ctrl.push = fire && do_push;
    val_ctrl.pop  = fire && do_pop;
    // New minimum (ties kept) on push; drop the minimum when it leaves.
    min_ctrl.push = fire && do_push && (min_cnt_q != min_stk_pkg::CNT_FULL) &&
                    ((min_cnt_q == '0) || (push_value_i <= min_cell[0]));
    min_ctrl.pop  = fire && do_pop && (min_cnt_q != '0) &&
                    (val_cell[0] == min_cell[0]);
  end

  always_comb begin
    val_cnt_d = val_cnt_q;
    min_cnt_d = min_cnt_q;
    if (val_ctrl.push) val_cnt_d = val_cnt_q + 1'b1;
    if (val_ctrl.pop)  val_cnt_d = val_cnt_q - 1'b1;
    if (min_ctrl.push) min_cnt_d = min_cnt_q + 1'b1;
    if (min_ctrl.pop)  min_cnt_d = min_cnt_q - 1'b1;
  end

  // Tops after the operation, seen one step ahead of the shift.
  always_comb begin
    if (val_ctrl.push) begin
      top_d = push_value_i;
    end else if (val_ctrl.pop) begin
      top_d = val_cell[1];
    end else begin
      top_d = val_cell[0];
    end
    if (val_cnt_d == '0) top_d = '0;

    if (min_ctrl.push) begin
      min_d = push_value_i;
    end else if (min_ctrl.pop) begin
      min_d = min_cell[1];
    end else begin
      min_d = min_cell[0];
    end
    if (min_cnt_d == '0) min_d = '0;
  end

  // Two chains of cells.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic signed [DataW-1:0] val_above, val_below, min_above, min_below;

    if (i == 0) begin : g_head
      assign val_above = push_value_i;
      assign min_above = push_value_i;
    end else begin : g_mid_a
      assign val_above = val_cell[i-1];
      assign min_above = min_cell[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign val_below = val_cell[i];
      assign min_below = min_cell[i];
    end else begin : g_mid_b
      assign val_below = val_cell[i+1];
      assign min_below = min_cell[i+1];
    end

    min_stk_cell u_val_cell (
      .clk_i   (clk_i),
      .ctrl_i  (val_ctrl),
      .above_i (val_above),
      .below_i (val_below),
      .value_o (val_cell[i])
    );

    min_stk_cell u_min_cell (
      .clk_i   (clk_i),
      .ctrl_i  (min_ctrl),
      .above_i (min_above),
      .below_i (min_below),
      .value_o (min_cell[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_cnt_q   <= '0;
      min_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      val_cnt_q <= val_cnt_d;
      min_cnt_q <= min_cnt_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      top_q    <= top_d;
      min_q    <= min_d;
      empty_q  <= (val_cnt_d == '0);
      status_q <= status_d;
      depth_q  <= min_stk_pkg::DEPTH_W'(val_cnt_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign top_value_o  = top_q;
  assign min_value_o  = min_q;
  assign is_empty_o   = empty_q;
  assign status_o     = status_q;
  assign depth_used_o = depth_q;

endmodule

// ===== sv/min_stk_chk.sv =====
module min_stk_chk (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  input  logic signed [min_stk_pkg::DATA_W-1:0]  top_value_o,
  input  logic signed [min_stk_pkg::DATA_W-1:0]  min_value_o,
  input  logic                                   is_empty_o,
  input  logic [min_stk_pkg::STAT_W-1:0]         status_o
);

  // A stalled item stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(top_value_o) &&
    $stable(min_value_o) && $stable(status_o))
    else $error("stalled output item changed");

  // Empty stack reads zero on both tops.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> top_value_o == '0 && min_value_o == '0)
    else $error("empty stack with nonzero top or minimum");

  // Minimum never exceeds the top.
  a_min_le_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_empty_o |-> min_value_o <= top_value_o)
    else $error("minimum above top value");

  // Underflow only on an empty stack; overflow only on a non-empty one.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != min_stk_pkg::ST_UNDERFLOW || is_empty_o) &&
    (status_o != min_stk_pkg::ST_OVERFLOW || !is_empty_o))
    else $error("status inconsistent with stack fill");

endmodule

bind min_tracking_stack min_stk_chk u_min_stk_chk (.*);
